// ===== src/e2r_pkg.sv =====
// Shared constants and types for the Euler angle to rotation matrix block.
package e2r_pkg;

  localparam int QW        = 63;
  localparam int SUM_W     = 64;
  localparam int SIN_TERMS = 9;
  localparam int COS_TERMS = 10;
  localparam int MUL_LAT   = 2;
  localparam int DIGIT_W   = 16;
  localparam int DIGITS    = 4;
  localparam int DIV_W     = DIGIT_W * DIGITS;
  localparam int DIV_RW    = 9;
  localparam int RECIP_SH  = 34;
  localparam int DIV_LAT   = 2 * DIGITS;
  localparam int CELL_LAT  = MUL_LAT + DIV_LAT;
  localparam int FRONT_LAT = 2 * MUL_LAT;
  localparam int BACK_LAT  = 5;

  localparam logic [QW-1:0] ONE_Q62 = QW'(64'h4000_0000_0000_0000);
  localparam logic [QW-1:0] PI4_Q62 = QW'(64'h3243_F6A8_885A_308D);

  typedef struct packed {
    logic [QW-1:0]           x2;
    logic [QW-1:0]           st;
    logic [QW-1:0]           ct;
    logic signed [SUM_W-1:0] ssum;
    logic signed [SUM_W-1:0] csum;
  } lane_t;

endpackage

// ===== src/e2r_mul.sv =====
// Two-stage truncating Q62 multiplier built from four partial products of the 31- and 32-bit operand halves.
module e2r_mul (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [e2r_pkg::QW-1:0] a_i,
  input  logic [e2r_pkg::QW-1:0] b_i,
  output logic [e2r_pkg::QW-1:0] p_o
);
  import e2r_pkg::*;

  logic [61:0]  hh_q;
  logic [62:0]  hl_q;
  logic [62:0]  lh_q;
  logic [63:0]  ll_q;
  logic [QW-1:0] p_q;
  logic [125:0] full;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= 62'(a_i[62:32]) * 62'(b_i[62:32]);
      hl_q <= 63'(a_i[62:32]) * 63'(b_i[31:0]);
      lh_q <= 63'(a_i[31:0]) * 63'(b_i[62:32]);
      ll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    end
  end

  assign full = (126'(hh_q) << 64) + (126'(hl_q) << 32) + (126'(lh_q) << 32) + 126'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= full[124:62];
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/e2r_div.sv =====
// Pipelined truncating division by a small constant, one 16-bit digit per two stages.
module e2r_div #(
  parameter int D = 3
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [e2r_pkg::QW-1:0] n_i,
  output logic [e2r_pkg::QW-1:0] q_o
);
  import e2r_pkg::*;

  localparam int VW  = DIV_RW + DIGIT_W;
  localparam int PWW = VW + RECIP_SH;
  localparam longint unsigned RECIP_L = ((64'd1 << RECIP_SH) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(RECIP_L);

  logic [DIV_W-1:0]  na_q [DIGITS];
  logic [DIV_W-1:0]  qa_q [DIGITS];
  logic [VW-1:0]     va_q [DIGITS];
  logic [PWW-1:0]    pa_q [DIGITS];
  logic [DIV_W-1:0]  nb_q [DIGITS];
  logic [DIV_W-1:0]  qb_q [DIGITS];
  logic [DIV_RW-1:0] rb_q [DIGITS];

  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    logic [DIV_W-1:0]   nin;
    logic [DIV_W-1:0]   qin;
    logic [DIV_RW-1:0]  rin;
    logic [VW-1:0]      v;
    logic [DIGIT_W-1:0] qd;
    logic [VW-1:0]      rem;

    if (g == 0) begin : g_first
      assign nin = DIV_W'(n_i);
      assign qin = '0;
      assign rin = '0;
    end else begin : g_next
      assign nin = nb_q[g-1];
      assign qin = qb_q[g-1];
      assign rin = rb_q[g-1];
    end

    assign v   = {rin, nin[DIV_W-1-DIGIT_W*g -: DIGIT_W]};
    assign qd  = pa_q[g][RECIP_SH +: DIGIT_W];
    assign rem = va_q[g] - VW'(qd) * VW'(D);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        na_q[g] <= nin;
        qa_q[g] <= qin;
        va_q[g] <= v;
        pa_q[g] <= PWW'(v) * PWW'(RECIP);
        nb_q[g] <= na_q[g];
        qb_q[g] <= {qa_q[g][DIV_W-DIGIT_W-1:0], qd};
        rb_q[g] <= rem[DIV_RW-1:0];
      end
    end
  end

  assign q_o = qb_q[DIGITS-1][QW-1:0];

endmodule

// ===== src/e2r_cell.sv =====
// One series cell: adds the next cosine Taylor term and, for K up to SIN_TERMS, the next sine term to the running sums.
module e2r_cell #(
  parameter int K = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  e2r_pkg::lane_t lane_i,
  output e2r_pkg::lane_t lane_o
);
  import e2r_pkg::*;

  localparam int DS     = (2 * K) * (2 * K + 1);
  localparam int DC     = (2 * K - 1) * (2 * K);
  localparam bit SIN_EN = (K <= SIN_TERMS);
  localparam bit NEG    = (K % 2 == 1);

  lane_t          dl_q [CELL_LAT];
  logic [QW-1:0]  cp;
  logic [QW-1:0]  ct_n;
  logic [QW-1:0]  st_n;
  logic signed [SUM_W-1:0] ct_s;
  logic signed [SUM_W-1:0] st_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q[0] <= lane_i;
      for (int i = 1; i < CELL_LAT; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  e2r_mul u_cmul (.clk_i(clk_i), .en_i(en_i), .a_i(lane_i.ct), .b_i(lane_i.x2), .p_o(cp));
  e2r_div #(.D(DC)) u_cdiv (.clk_i(clk_i), .en_i(en_i), .n_i(cp), .q_o(ct_n));

  if (SIN_EN) begin : g_sin
    logic [QW-1:0] sp;
    e2r_mul u_smul (.clk_i(clk_i), .en_i(en_i), .a_i(lane_i.st), .b_i(lane_i.x2), .p_o(sp));
    e2r_div #(.D(DS)) u_sdiv (.clk_i(clk_i), .en_i(en_i), .n_i(sp), .q_o(st_n));
  end else begin : g_nosin
    assign st_n = '0;
  end

  assign ct_s = signed'(SUM_W'(ct_n));
  assign st_s = signed'(SUM_W'(st_n));

  always_comb begin
    lane_o.x2   = dl_q[CELL_LAT-1].x2;
    lane_o.ct   = ct_n;
    lane_o.st   = st_n;
    lane_o.csum = NEG ? dl_q[CELL_LAT-1].csum - ct_s : dl_q[CELL_LAT-1].csum + ct_s;
    if (!SIN_EN) begin
      lane_o.ssum = dl_q[CELL_LAT-1].ssum;
    end else if (NEG) begin
      lane_o.ssum = dl_q[CELL_LAT-1].ssum - st_s;
    end else begin
      lane_o.ssum = dl_q[CELL_LAT-1].ssum + st_s;
    end
  end

endmodule

// ===== src/euler_to_rotation_matrix.sv =====
// Top level: Euler angles to 3x3 direction cosine matrix.
//
// Takes one word of pitch, yaw and roll binary angles each cycle and returns the
// nine matrix entries in signed Q2.FRAC_BITS, at a sustained rate of one word per
// cycle while the output is taken. The latency is set by the row of ten series
// cells per angle, each a two-stage 63-bit multiplier followed by an eight-stage
// division by a constant, plus four front stages that scale the angle and square
// it and six stages of rounding, products and the output register.
// tuser selects the plain matrix (0) or its transpose (1). The whole pipeline holds
// when the output word is not taken.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pitch_angle, yaw_angle, roll_angle
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // mode
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  import e2r_pkg::*;

  localparam int ODW  = ((9 * (FRAC_BITS + 2) + 7) / 8) * 8;
  localparam int OB   = ANGLE_BITS - 3;
  localparam int OW   = FRAC_BITS + 2;
  localparam int PW   = 2 * OW;
  localparam int SW   = PW + 1;
  localparam int SH   = 62 - FRAC_BITS;
  localparam int RSH  = 62 - OB;
  localparam int B0I  = FRONT_LAT + COS_TERMS * CELL_LAT;
  localparam int LAT  = B0I + BACK_LAT;
  localparam logic signed [OW:0] ONE_X = signed'((OW + 1)'(1) << FRAC_BITS);
  localparam logic signed [OW:0] NEG_ONE_X = -ONE_X;

  typedef struct packed {
    logic           mode;
    logic [2:0][2:0] oct;
  } side_t;

  function automatic logic signed [OW-1:0] rnd62(input logic signed [SUM_W-1:0] p);
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] r;
    logic [OW-1:0]    rv;
    neg = p[SUM_W-1];
    mag = neg ? SUM_W'(-p) : SUM_W'(p);
    r   = (mag + (SUM_W'(1) << (SH - 1))) >> SH;
    rv  = r[OW-1:0];
    return neg ? signed'(~rv + 1'b1) : signed'(rv);
  endfunction

  function automatic logic signed [OW:0] rndp(input logic signed [SW-1:0] p);
    logic          neg;
    logic [SW-1:0] mag;
    logic [SW-1:0] r;
    logic [OW:0]   rv;
    neg = p[SW-1];
    mag = neg ? SW'(-p) : SW'(p);
    r   = (mag + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rv  = r[OW:0];
    return neg ? signed'(~rv + 1'b1) : signed'(rv);
  endfunction

  function automatic logic signed [OW-1:0] fin(input logic signed [SW-1:0] p);
    logic signed [OW:0] v;
    v = rndp(p);
    if (v > ONE_X) begin
      v = ONE_X;
    end else if (v < NEG_ONE_X) begin
      v = NEG_ONE_X;
    end
    return v[OW-1:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld_q;
  logic           out_vld_q;
  side_t          sd_q [LAT];
  side_t          sd_in;

  lane_t ln [3][COS_TERMS+1];
  logic signed [SUM_W-1:0] ss_q [3];
  logic signed [SUM_W-1:0] cc_q [3];
  logic signed [OW-1:0] sn_d [3];
  logic signed [OW-1:0] cs_d [3];
  logic signed [OW-1:0] sn_q [3];
  logic signed [OW-1:0] cs_q [3];
  logic signed [OW-1:0] s2_q [3];
  logic signed [OW-1:0] c2_q [3];
  logic signed [OW-1:0] s3_q [3];
  logic signed [OW-1:0] c3_q [3];
  logic signed [PW-1:0] pcy_q;
  logic signed [PW-1:0] psy_q;
  logic signed [OW:0]   t_r;
  logic signed [OW:0]   u_r;
  logic signed [OW-1:0] t_q;
  logic signed [OW-1:0] u_q;
  logic signed [PW-1:0] pr_q [12];
  logic signed [OW-1:0] sp4_q;
  logic signed [SW-1:0] e [12];
  logic signed [OW-1:0] mm [9];
  logic [9*OW-1:0]      out_d;
  logic [9*OW-1:0]      out_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = ODW'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LAT-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[LAT-1];
    end
  end

  assign sd_in.mode = s_axis_tuser[0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_in;
      for (int i = 1; i < LAT; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_angle
    logic [ANGLE_BITS-1:0] ang;
    logic [OB:0]           remc;
    logic [QW-1:0]         rq;
    logic [QW-1:0]         x;
    logic [QW-1:0]         x2;
    logic [QW-1:0]         x1_q;
    logic [QW-1:0]         xd_q;

    assign ang          = s_axis_tdata[a*ANGLE_BITS +: ANGLE_BITS];
    assign sd_in.oct[a] = ang[ANGLE_BITS-1 -: 3];
    assign remc = ang[OB] ? ((OB + 1)'(1) << OB) - {1'b0, ang[OB-1:0]} : {1'b0, ang[OB-1:0]};
    assign rq   = QW'(remc) << RSH;

    e2r_mul u_xmul (.clk_i(clk_i), .en_i(en), .a_i(rq), .b_i(PI4_Q62), .p_o(x));
    e2r_mul u_x2mul (.clk_i(clk_i), .en_i(en), .a_i(x), .b_i(x), .p_o(x2));

    always_ff @(posedge clk_i) begin
      if (en) begin
        x1_q <= x;
        xd_q <= x1_q;
      end
    end

    always_comb begin
      ln[a][0].x2   = x2;
      ln[a][0].st   = xd_q;
      ln[a][0].ct   = ONE_Q62;
      ln[a][0].ssum = signed'(SUM_W'(xd_q));
      ln[a][0].csum = signed'(SUM_W'(ONE_Q62));
    end

    for (genvar k = 0; k < COS_TERMS; k++) begin : g_cell
      e2r_cell #(.K(k + 1)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .lane_i(ln[a][k]),
        .lane_o(ln[a][k+1])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ss_q[a] <= ln[a][COS_TERMS].ssum;
        cc_q[a] <= ln[a][COS_TERMS].csum;
      end
    end
  end

  always_comb begin
    logic [2:0]           oct;
    logic signed [OW-1:0] sv;
    logic signed [OW-1:0] cv;
    logic signed [OW-1:0] sq;
    logic signed [OW-1:0] cq;
    for (int a = 0; a < 3; a++) begin
      oct = sd_q[B0I].oct[a];
      sv  = rnd62(ss_q[a]);
      cv  = rnd62(cc_q[a]);
      sq  = oct[0] ? cv : sv;
      cq  = oct[0] ? sv : cv;
      unique case (oct[2:1])
        2'b00: begin
          sn_d[a] = sq;
          cs_d[a] = cq;
        end
        2'b01: begin
          sn_d[a] = cq;
          cs_d[a] = -sq;
        end
        2'b10: begin
          sn_d[a] = -sq;
          cs_d[a] = -cq;
        end
        default: begin
          sn_d[a] = -cq;
          cs_d[a] = sq;
        end
      endcase
    end
  end

  assign t_r = rndp(SW'(pcy_q));
  assign u_r = rndp(SW'(psy_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q  <= sn_d;
      cs_q  <= cs_d;
      s2_q  <= sn_q;
      c2_q  <= cs_q;
      pcy_q <= PW'(sn_q[0]) * PW'(cs_q[1]);
      psy_q <= PW'(sn_q[0]) * PW'(sn_q[1]);
      s3_q  <= s2_q;
      c3_q  <= c2_q;
      t_q   <= t_r[OW-1:0];
      u_q   <= u_r[OW-1:0];
      pr_q[0]  <= PW'(c3_q[0]) * PW'(c3_q[1]);
      pr_q[1]  <= PW'(t_q) * PW'(c3_q[2]);
      pr_q[2]  <= PW'(s3_q[1]) * PW'(s3_q[2]);
      pr_q[3]  <= PW'(t_q) * PW'(s3_q[2]);
      pr_q[4]  <= PW'(s3_q[1]) * PW'(c3_q[2]);
      pr_q[5]  <= PW'(c3_q[0]) * PW'(c3_q[2]);
      pr_q[6]  <= PW'(c3_q[0]) * PW'(s3_q[2]);
      pr_q[7]  <= PW'(c3_q[0]) * PW'(s3_q[1]);
      pr_q[8]  <= PW'(u_q) * PW'(c3_q[2]);
      pr_q[9]  <= PW'(c3_q[1]) * PW'(s3_q[2]);
      pr_q[10] <= PW'(u_q) * PW'(s3_q[2]);
      pr_q[11] <= PW'(c3_q[1]) * PW'(c3_q[2]);
      sp4_q    <= s3_q[0];
      out_q    <= out_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      e[i] = SW'(pr_q[i]);
    end
    mm[0] = fin(e[0]);
    mm[1] = fin(e[2] - e[1]);
    mm[2] = fin(e[3] + e[4]);
    mm[3] = sp4_q;
    mm[4] = fin(e[5]);
    mm[5] = fin(-e[6]);
    mm[6] = fin(-e[7]);
    mm[7] = fin(e[8] + e[9]);
    mm[8] = fin(e[11] - e[10]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        out_d[(i*3+j)*OW +: OW] = sd_q[LAT-1].mode ? mm[j*3+i] : mm[i*3+j];
      end
    end
  end

endmodule
